// ===== rtl/pbfp_pkg.sv =====
// Shared types and constants for the power board frame parser.
// Used by the front, queue, back and top modules; depends on nothing.
`default_nettype none
package pbfp_pkg;

	localparam int unsigned CHUNK_MAX   = 255;
	localparam int unsigned STORE_DEPTH = 18;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [7:0] BYTE_START    = 8'hAA;
	localparam logic [7:0] BYTE_CURRENT  = 8'hA1;
	localparam logic [7:0] BYTE_HUMID    = 8'hA3;
	localparam logic [7:0] BYTE_HEART    = 8'hA4;
	localparam logic [7:0] BYTE_SWITCH   = 8'hA5;
	localparam logic [7:0] BYTE_END0     = 8'hAF;
	localparam logic [7:0] BYTE_END1     = 8'hFF;
	localparam logic [7:0] BYTE_SW_ACK   = 8'h65;
	localparam logic [7:0] BYTE_HB_CODE  = 8'hCC;
	localparam logic [7:0] BYTE_HB_SUM   = 8'h7B;

	localparam logic [3:0] HEART_LAST    = 4'd5;
	localparam logic [3:0] CURRENT_LAST  = 4'd8;

	typedef enum logic [1:0] {
		KIND_CURRENT = 2'd0,
		KIND_HUMID   = 2'd1,
		KIND_HEART   = 2'd2,
		KIND_ACK     = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t                          kind;
		logic [STORE_DEPTH-1:0][7:0]    payload;
	} job_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} push_t;

	function automatic logic [7:0] heart_reply(input logic [3:0] pos);
		logic [7:0] r;
		case (pos)
			4'd0: r = BYTE_START;
			4'd1: r = BYTE_HEART;
			4'd2: r = BYTE_HB_CODE;
			4'd3: r = BYTE_HB_SUM;
			4'd4: r = BYTE_END0;
			4'd5: r = BYTE_END1;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/power_board_frame_parser_unit.sv =====
// Top level of the power board frame parser.
// Instantiates pbfp_front, pbfp_queue and pbfp_back; uses pbfp_pkg.
//
// Received bytes enter one per cycle on the slave stream, tlast marking the
// end of a receive chunk; the input takes a byte every cycle while the
// two-entry job queue has room. A heartbeat header or a frame that passes its
// length and checksum checks (and, for a switch frame, the acknowledge code
// check) becomes one job, which the back end expands into 9 (current), 1
// (humidity/temperature), 6 (heartbeat reply) or 1 (switch acknowledge) result
// transactions, one per cycle as the master side accepts them, tlast on the
// final one. Input stalls only when two jobs wait for expansion.
`default_nettype none
module power_board_frame_parser_unit
	import pbfp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // rx_byte[7:0]
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // channel[3:0], value_a[19:4], value_b[35:20], zero
	output logic [1:0]       m_tuser,   // kind[1:0]
	output logic             m_tlast
);

	push_t       push;
	logic        q_not_full;
	logic        head_valid;
	job_t        head;
	logic        pop;
	kind_t       out_kind;
	logic [3:0]  out_channel;
	logic [15:0] out_value_a;
	logic [15:0] out_value_b;

	assign s_tready = q_not_full;

	pbfp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (s_tvalid && s_tready),
		.rx_byte   (s_tdata),
		.chunk_end (s_tlast),
		.push      (push)
	);

	pbfp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.not_full   (q_not_full),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	pbfp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_kind    (out_kind),
		.out_channel (out_channel),
		.out_value_a (out_value_a),
		.out_value_b (out_value_b),
		.out_last    (m_tlast)
	);

	assign m_tuser = out_kind;
	assign m_tdata = {4'h0, out_value_b, out_value_a, out_channel};

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> q_not_full)
		else $error("job pushed into full queue");

	a_pop_has_job: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("job popped from empty queue");

	a_heart_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == KIND_HEART)) |-> (m_tlast == (m_tdata[3:0] == HEART_LAST)))
		else $error("heartbeat reply run framed wrongly");

	a_current_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == KIND_CURRENT)) |->
		(m_tlast == (m_tdata[3:0] == CURRENT_LAST)))
		else $error("current sample run framed wrongly");

endmodule
`default_nettype wire

// ===== rtl/pbfp_front.sv =====
// Byte-level parser: hunts headers, stores payload, checks frames.
// Pushes one job per heartbeat or valid frame; uses pbfp_pkg.
`default_nettype none
module pbfp_front
	import pbfp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [7:0] rx_byte,
	input  wire logic       chunk_end,
	output push_t           push
);

	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_COLLECT = 2'd1,
		PH_DONE    = 2'd2
	} phase_t;

	phase_t                      phase_q;
	kind_t                       fkind_q;
	logic [7:0]                  bat_q;
	logic [7:0]                  prev_q;
	logic [7:0]                  prev2_q;
	logic [7:0]                  pos_q;
	logic [7:0]                  store_q [STORE_DEPTH];
	logic [STORE_DEPTH-1:0][7:0] store_flat;

	logic       in_window;
	logic       hdr_hit;
	logic       is_heart;
	logic       is_type;
	logic       end_hit;
	logic       frame_ok;
	logic [7:0] sum_cur;
	logic [7:0] sum_hum;
	logic [7:0] sum_ack;
	kind_t      type_kind;

	always_comb begin
		for (int i = 0; i < STORE_DEPTH; i++) begin
			store_flat[i] = store_q[i];
		end
	end

	assign in_window = pos_q < CHUNK_MAX[7:0];
	assign hdr_hit   = in_window && (phase_q == PH_HUNT) && (prev_q == BYTE_START);
	assign is_heart  = rx_byte == BYTE_HEART;
	assign is_type   = (rx_byte == BYTE_CURRENT) || (rx_byte == BYTE_HUMID) ||
		(rx_byte == BYTE_SWITCH);
	assign end_hit   = in_window && (phase_q == PH_COLLECT) && (rx_byte == BYTE_END1) &&
		(prev_q == BYTE_END0) && (bat_q != 8'd0);

	assign sum_cur = store_q[0] + store_q[2] + store_q[15] + BYTE_END0;
	assign sum_hum = store_q[0] + store_q[3] + BYTE_END0;
	assign sum_ack = store_q[0] + BYTE_END0;

	always_comb begin
		case (rx_byte)
			BYTE_CURRENT: type_kind = KIND_CURRENT;
			BYTE_HUMID:   type_kind = KIND_HUMID;
			default:      type_kind = KIND_ACK;
		endcase
	end

	always_comb begin
		case (fkind_q)
			KIND_CURRENT: frame_ok = (bat_q >= 8'd19) && (sum_cur == prev2_q);
			KIND_HUMID:   frame_ok = (bat_q >= 8'd5) && (sum_hum == prev2_q);
			KIND_ACK:     frame_ok = (bat_q >= 8'd2) && (store_q[0] == BYTE_SW_ACK) &&
				(sum_ack == prev2_q);
			default:      frame_ok = 1'b0;
		endcase
	end

	always_comb begin
		push.valid       = 1'b0;
		push.job.kind    = fkind_q;
		push.job.payload = store_flat;
		if (accept && hdr_hit && is_heart) begin
			push.valid    = 1'b1;
			push.job.kind = KIND_HEART;
		end else if (accept && end_hit && frame_ok) begin
			push.valid = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			fkind_q <= KIND_CURRENT;
			bat_q   <= '0;
			prev_q  <= '0;
			prev2_q <= '0;
			pos_q   <= '0;
		end else if (accept) begin
			if (in_window) begin
				pos_q   <= pos_q + 8'd1;
				prev2_q <= prev_q;
				prev_q  <= rx_byte;
				if (hdr_hit) begin
					if (is_heart) begin
						phase_q <= PH_DONE;
					end else if (is_type) begin
						phase_q <= PH_COLLECT;
						fkind_q <= type_kind;
						bat_q   <= '0;
					end
				end else if (phase_q == PH_COLLECT) begin
					if (end_hit) begin
						phase_q <= PH_DONE;
					end else if (bat_q != 8'hFF) begin
						bat_q <= bat_q + 8'd1;
					end
				end
			end
			if (chunk_end) begin
				phase_q <= PH_HUNT;
				bat_q   <= '0;
				prev_q  <= '0;
				prev2_q <= '0;
				pos_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_window && (phase_q == PH_COLLECT) && !end_hit &&
			(bat_q < STORE_DEPTH[7:0])) begin
			store_q[bat_q[4:0]] <= rx_byte;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/pbfp_queue.sv =====
// Two-entry job queue between the parser front and the result back end.
// Uses pbfp_pkg job types.
`default_nettype none
module pbfp_queue
	import pbfp_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire push_t push,
	output logic       not_full,
	output logic       head_valid,
	output job_t       head,
	input  wire logic  pop
);

	job_t       mem_q [QUEUE_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign not_full   = count_q != QUEUE_DEPTH[1:0];
	assign head_valid = count_q != 2'd0;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push.valid, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.job;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/pbfp_back.sv =====
// Result back end: expands the head job into result transactions.
// Drives the registered output slot; uses pbfp_pkg.
`default_nettype none
module pbfp_back
	import pbfp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic head_valid,
	input  wire job_t head,
	output logic      pop,
	output logic      out_valid,
	input  wire logic out_ready,
	output kind_t     out_kind,
	output logic [3:0]  out_channel,
	output logic [15:0] out_value_a,
	output logic [15:0] out_value_b,
	output logic      out_last
);

	logic [3:0]  idx_q;
	logic        advance;
	logic [3:0]  item_channel;
	logic [15:0] item_a;
	logic [15:0] item_b;
	logic        item_last;
	logic [15:0] cur_word;

	always_comb begin
		case (idx_q)
			4'd0:    cur_word = {head.payload[0],  head.payload[1]};
			4'd1:    cur_word = {head.payload[2],  head.payload[3]};
			4'd2:    cur_word = {head.payload[4],  head.payload[5]};
			4'd3:    cur_word = {head.payload[6],  head.payload[7]};
			4'd4:    cur_word = {head.payload[8],  head.payload[9]};
			4'd5:    cur_word = {head.payload[10], head.payload[11]};
			4'd6:    cur_word = {head.payload[12], head.payload[13]};
			4'd7:    cur_word = {head.payload[14], head.payload[15]};
			4'd8:    cur_word = {head.payload[16], head.payload[17]};
			default: cur_word = '0;
		endcase
	end

	always_comb begin
		item_channel = '0;
		item_a       = '0;
		item_b       = '0;
		item_last    = 1'b1;
		case (head.kind)
			KIND_CURRENT: begin
				item_channel = idx_q;
				item_a       = cur_word;
				item_last    = idx_q == CURRENT_LAST;
			end
			KIND_HUMID: begin
				item_a = {head.payload[0], head.payload[1]};
				item_b = {head.payload[2], head.payload[3]};
			end
			KIND_HEART: begin
				item_channel = idx_q;
				item_a       = {8'h00, heart_reply(idx_q)};
				item_last    = idx_q == HEART_LAST;
			end
			default: begin
				item_last = 1'b1;
			end
		endcase
	end

	assign advance = head_valid && (!out_valid || out_ready);
	assign pop     = advance && item_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (advance) begin
				out_valid <= 1'b1;
				idx_q     <= item_last ? 4'd0 : idx_q + 4'd1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_kind    <= head.kind;
			out_channel <= item_channel;
			out_value_a <= item_a;
			out_value_b <= item_b;
			out_last    <= item_last;
		end
	end

endmodule
`default_nettype wire

// ===== tb/sv/power_board_frame_parser_unit_tb.sv =====
// Self-checking testbench for power_board_frame_parser_unit.
// Predicts results from the accepted byte stream and checks each result
// transaction against the oldest prediction; uses pbfp_pkg.
module power_board_frame_parser_unit_tb;
	import pbfp_pkg::*;

	typedef enum logic [1:0] {
		SCAN_HUNT    = 2'd0,
		SCAN_COLLECT = 2'd1,
		SCAN_DONE    = 2'd2
	} scan_phase_t;

	typedef struct {
		kind_t       kind;
		logic [3:0]  channel;
		logic [15:0] value_a;
		logic [15:0] value_b;
		logic        last;
	} result_t;

	localparam logic [47:0] HEART_REPLY = {BYTE_END1, BYTE_END0, BYTE_HB_SUM,
		BYTE_HB_CODE, BYTE_HEART, BYTE_START};
	localparam logic [7:0] HUMID_SELF_SUM = 8'h51;
	localparam logic [7:0] SWITCH_SUM     = 8'h14;
	localparam int RANDOM_BYTES = 430;
	localparam int IDLE_PCT     = 16;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	scan_phase_t scan_phase = SCAN_HUNT;
	kind_t       frame_kind = KIND_CURRENT;
	logic [7:0]  after_type = 8'h00;
	logic [7:0]  prev_byte = 8'h00;
	logic [7:0]  prev2_byte = 8'h00;
	logic [7:0]  frame_store [STORE_DEPTH];
	int          chunk_pos = 0;

	result_t     pending_results [$];
	result_t     want;
	logic [7:0]  chunk_bytes [$];
	int          mismatch_count = 0;
	int          bytes_sent = 0;
	int          sink_hold = 0;
	bit          calm = 1'b0;

	power_board_frame_parser_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic void push_result(input kind_t kind, input logic [3:0] channel,
			input logic [15:0] value_a, input logic [15:0] value_b, input logic last);
		result_t r;
		r.kind = kind;
		r.channel = channel;
		r.value_a = value_a;
		r.value_b = value_b;
		r.last = last;
		pending_results.push_back(r);
	endfunction

	function automatic void close_frame(input logic [7:0] sum, input int n);
		int i;
		case (frame_kind)
		KIND_CURRENT: begin
			if (n >= 18 && 8'(frame_store[0] + frame_store[2] + frame_store[15] + BYTE_END0) == sum) begin
				for (i = 0; i < 9; i++)
					push_result(KIND_CURRENT, 4'(i), {frame_store[2*i], frame_store[2*i+1]},
						16'h0000, i == CURRENT_LAST);
			end
		end
		KIND_HUMID: begin
			if (n >= 4 && 8'(frame_store[0] + frame_store[3] + BYTE_END0) == sum)
				push_result(KIND_HUMID, 4'd0, {frame_store[0], frame_store[1]},
					{frame_store[2], frame_store[3]}, 1'b1);
		end
		default: begin
			if (n >= 1 && frame_store[0] == BYTE_SW_ACK && 8'(frame_store[0] + BYTE_END0) == sum)
				push_result(KIND_ACK, 4'd0, 16'h0000, 16'h0000, 1'b1);
		end
		endcase
	endfunction

	function automatic void parse_rx_byte(input logic [7:0] b, input logic chunk_end);
		int i;
		if (chunk_pos < CHUNK_MAX) begin
			chunk_pos++;
			case (scan_phase)
			SCAN_HUNT: begin
				if (prev_byte == BYTE_START) begin
					if (b == BYTE_HEART) begin
						for (i = 0; i < 6; i++)
							push_result(KIND_HEART, 4'(i), {8'h00, HEART_REPLY[8*i +: 8]},
								16'h0000, i == HEART_LAST);
						scan_phase = SCAN_DONE;
					end else if (b == BYTE_CURRENT || b == BYTE_HUMID || b == BYTE_SWITCH) begin
						frame_kind = (b == BYTE_CURRENT) ? KIND_CURRENT :
							(b == BYTE_HUMID) ? KIND_HUMID : KIND_ACK;
						scan_phase = SCAN_COLLECT;
						after_type = 8'h00;
					end
				end
			end
			SCAN_COLLECT: begin
				if (b == BYTE_END1 && prev_byte == BYTE_END0 && after_type >= 1) begin
					close_frame(prev2_byte, int'(after_type) - 1);
					scan_phase = SCAN_DONE;
				end else begin
					if (after_type < STORE_DEPTH)
						frame_store[after_type] = b;
					if (after_type < 8'd255)
						after_type++;
				end
			end
			default: ;
			endcase
			prev2_byte = prev_byte;
			prev_byte = b;
		end
		if (chunk_end) begin
			scan_phase = SCAN_HUNT;
			after_type = 8'h00;
			prev_byte = 8'h00;
			prev2_byte = 8'h00;
			chunk_pos = 0;
		end
	endfunction

	task automatic report_mismatch(input string field, input logic [15:0] got,
			input logic [15:0] exp_val);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("mismatch on %s at %0t: got %h, expected %h", field, $realtime, got, exp_val);
	endtask

	// check each result transaction against the oldest prediction
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected transaction", m_tdata[19:4], 16'h0000);
			end else begin
				want = pending_results.pop_front();
				if (m_tuser !== want.kind)
					report_mismatch("kind", 16'(m_tuser), 16'(want.kind));
				if (m_tdata[3:0] !== want.channel)
					report_mismatch("channel", 16'(m_tdata[3:0]), 16'(want.channel));
				if (m_tdata[19:4] !== want.value_a)
					report_mismatch("value_a", m_tdata[19:4], want.value_a);
				if (m_tdata[35:20] !== want.value_b)
					report_mismatch("value_b", m_tdata[35:20], want.value_b);
				if (m_tlast !== want.last)
					report_mismatch("last", 16'(m_tlast), 16'(want.last));
			end
		end
	end

	// result sink: random ready (always ready when calm), or hold off while sink_hold counts down
	initial begin
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (sink_hold > 0) begin
				m_tready = 1'b0;
				sink_hold--;
			end else begin
				m_tready = calm || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic chunk_end);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = b;
		s_tlast = chunk_end;
		do @(posedge clk); while (!s_tready);
		parse_rx_byte(b, chunk_end);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_chunk();
		int i;
		for (i = 0; i < chunk_bytes.size(); i++)
			send_byte(chunk_bytes[i], i == chunk_bytes.size() - 1);
		chunk_bytes.delete();
	endtask

	task automatic add_noise(input int count, input int fill);
		repeat (count)
			chunk_bytes.push_back((fill < 0) ? 8'($urandom_range(255)) : 8'(fill));
	endtask

	task automatic add_heartbeat();
		chunk_bytes.push_back(BYTE_START);
		chunk_bytes.push_back(BYTE_HEART);
	endtask

	// n counts payload bytes including the trailing checksum byte
	task automatic add_frame(input logic [7:0] ftype, input int n, input bit good_sum,
			input int fill);
		logic [7:0] pay [$];
		logic [7:0] skew;
		int i;
		skew = good_sum ? 8'h00 : 8'h01;
		for (i = 0; i < n; i++)
			pay.push_back((fill < 0) ? 8'($urandom_range(255)) : 8'(fill));
		case (ftype)
		BYTE_CURRENT: begin
			if (n >= 18)
				pay[n-1] = pay[0] + pay[2] + pay[15] + BYTE_END0 + skew;
		end
		BYTE_HUMID: begin
			if (n == 4)
				pay[0] = HUMID_SELF_SUM + skew;
			else if (n > 4)
				pay[n-1] = pay[0] + pay[3] + BYTE_END0 + skew;
		end
		BYTE_SWITCH: begin
			if (n >= 2) begin
				pay[0] = BYTE_SW_ACK;
				pay[n-1] = SWITCH_SUM + skew;
			end
		end
		default: ;
		endcase
		chunk_bytes.push_back(BYTE_START);
		chunk_bytes.push_back(ftype);
		for (i = 0; i < n; i++)
			chunk_bytes.push_back(pay[i]);
		chunk_bytes.push_back(BYTE_END0);
		chunk_bytes.push_back(BYTE_END1);
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_heartbeat();
		add_heartbeat();
		send_chunk();
		add_noise(2, 0);
		chunk_bytes.push_back(BYTE_START);
		add_heartbeat();
		add_heartbeat();
		send_chunk();
		add_heartbeat();
		add_frame(BYTE_HUMID, 5, 1'b1, -1);
		send_chunk();
	endtask

	task automatic test_current_frames();
		add_frame(BYTE_CURRENT, 18, 1'b1, 8'h00);
		send_chunk();
		add_frame(BYTE_CURRENT, 18, 1'b1, 8'hFF);
		send_chunk();
		add_frame(BYTE_CURRENT, 20, 1'b1, -1);
		send_chunk();
		add_frame(BYTE_CURRENT, 18, 1'b0, -1);
		send_chunk();
		add_frame(BYTE_CURRENT, 17, 1'b1, -1);
		send_chunk();
	endtask

	task automatic test_humidity_frames();
		add_frame(BYTE_HUMID, 4, 1'b1, 8'hFF);
		send_chunk();
		add_frame(BYTE_HUMID, 4, 1'b0, -1);
		send_chunk();
		add_frame(BYTE_HUMID, 5, 1'b1, 8'h00);
		send_chunk();
		add_frame(BYTE_HUMID, 6, 1'b0, -1);
		send_chunk();
		add_frame(BYTE_HUMID, 3, 1'b1, -1);
		send_chunk();
	endtask

	task automatic test_switch_frames();
		add_frame(BYTE_SWITCH, 2, 1'b1, -1);
		send_chunk();
		add_frame(BYTE_SWITCH, 3, 1'b0, -1);
		send_chunk();
		add_frame(BYTE_SWITCH, 1, 1'b1, 8'h65);
		send_chunk();
		add_frame(BYTE_SWITCH, 0, 1'b1, -1);
		send_chunk();
		// wrong acknowledge code with a matching sum
		chunk_bytes = '{BYTE_START, BYTE_SWITCH, 8'h64, 8'h13, BYTE_END0, BYTE_END1};
		send_chunk();
	endtask

	task automatic test_chunk_boundaries();
		add_frame(BYTE_HUMID, 5, 1'b1, -1);
		void'(chunk_bytes.pop_back());
		send_chunk();
		chunk_bytes.push_back(BYTE_END1);
		send_chunk();
		add_frame(BYTE_SWITCH, 2, 1'b1, -1);
		add_frame(BYTE_HUMID, 5, 1'b1, -1);
		send_chunk();
		add_frame(BYTE_HUMID, 5, 1'b0, -1);
		add_frame(BYTE_SWITCH, 2, 1'b1, -1);
		send_chunk();
		add_noise(12, -1);
		send_chunk();
		chunk_bytes.push_back(BYTE_START);
		send_chunk();
		chunk_bytes.push_back(BYTE_HEART);
		send_chunk();
	endtask

	task automatic test_overlong_chunk();
		add_noise(CHUNK_MAX - 1, 0);
		add_heartbeat();
		add_noise(3, 0);
		send_chunk();
		add_noise(CHUNK_MAX - 3, 0);
		add_heartbeat();
		send_chunk();
		add_noise(240, 0);
		add_frame(BYTE_CURRENT, 18, 1'b1, -1);
		send_chunk();
	endtask

	task automatic test_no_gaps();
		calm = 1'b1;
		repeat (3) begin
			add_frame(BYTE_CURRENT, 18, 1'b1, -1);
			send_chunk();
			add_heartbeat();
			send_chunk();
			add_frame(BYTE_HUMID, 4 + $urandom_range(3), 1'b1, -1);
			send_chunk();
		end
		calm = 1'b0;
	endtask

	task automatic test_result_holdoff();
		calm = 1'b1;
		sink_hold = 150;
		repeat (4) begin
			add_frame(BYTE_CURRENT, 18, 1'b1, -1);
			send_chunk();
			add_heartbeat();
			send_chunk();
		end
		calm = 1'b0;
	endtask

	task automatic test_random_traffic();
		int sel;
		int start_count;
		logic [7:0] ftype;
		start_count = bytes_sent;
		while (bytes_sent - start_count < RANDOM_BYTES) begin
			sel = $urandom_range(99);
			if ($urandom_range(3) == 0)
				add_noise($urandom_range(1, 4), -1);
			if (sel < 30) begin
				add_frame(BYTE_CURRENT, $urandom_range(18, 20), $urandom_range(9) != 0, -1);
			end else if (sel < 50) begin
				add_frame(BYTE_HUMID, $urandom_range(4, 7), $urandom_range(9) != 0, -1);
			end else if (sel < 63) begin
				add_frame(BYTE_SWITCH, $urandom_range(2, 4), $urandom_range(9) != 0, -1);
			end else if (sel < 73) begin
				add_heartbeat();
			end else if (sel < 83) begin
				case ($urandom_range(2))
				0: add_frame(BYTE_CURRENT, $urandom_range(17), 1'b1, -1);
				1: add_frame(BYTE_HUMID, $urandom_range(3), 1'b1, -1);
				default: add_frame(BYTE_SWITCH, $urandom_range(1), 1'b1, -1);
				endcase
			end else if (sel < 92) begin
				ftype = ($urandom_range(1) == 0) ? BYTE_HUMID : BYTE_CURRENT;
				add_frame(ftype, (ftype == BYTE_HUMID) ? 5 : 18, 1'b1, -1);
				repeat ($urandom_range(1, 4))
					void'(chunk_bytes.pop_back());
			end else begin
				add_noise($urandom_range(1, 30), -1);
			end
			if ($urandom_range(2) == 0)
				add_noise($urandom_range(1, 3), -1);
			send_chunk();
		end
	endtask

	initial begin
		foreach (frame_store[i])
			frame_store[i] = 8'h00;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_heartbeat();
		test_current_frames();
		test_humidity_frames();
		test_switch_frames();
		test_chunk_boundaries();
		test_overlong_chunk();
		test_no_gaps();
		test_result_holdoff();
		test_random_traffic();
		s_tvalid = 1'b0;
		s_tlast = 1'b0;
		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/pbfp_pkg.sv
rtl/pbfp_front.sv
rtl/pbfp_queue.sv
rtl/pbfp_back.sv
rtl/power_board_frame_parser_unit.sv
tb/sv/power_board_frame_parser_unit_tb.sv
